>>> src/taes_pkg.sv
// Shared types, codes and elaboration-time helpers of the time-aware exponential smoother.
package taes_pkg;

	// Width of the channel field on both channels.
	localparam int CH_W = 5;

	// Depth of the queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;

	// Time constant of the smoothing law in milliseconds.
	localparam int unsigned TIME_CONST_MS = 260;

	// One in Q2.62, the format used to derive the alpha table.
	localparam logic [63:0] Q62_ONE = 64'd1 << 62;

	// Terms of the series for exp(-1/260) in Q2.62, each the previous one over 260 * k.
	localparam logic [63:0] DECAY_T1 = Q62_ONE / (64'(TIME_CONST_MS) * 64'd1);
	localparam logic [63:0] DECAY_T2 = DECAY_T1 / (64'(TIME_CONST_MS) * 64'd2);
	localparam logic [63:0] DECAY_T3 = DECAY_T2 / (64'(TIME_CONST_MS) * 64'd3);
	localparam logic [63:0] DECAY_T4 = DECAY_T3 / (64'(TIME_CONST_MS) * 64'd4);
	localparam logic [63:0] DECAY_T5 = DECAY_T4 / (64'(TIME_CONST_MS) * 64'd5);
	localparam logic [63:0] DECAY_T6 = DECAY_T5 / (64'(TIME_CONST_MS) * 64'd6);
	localparam logic [63:0] DECAY_T7 = DECAY_T6 / (64'(TIME_CONST_MS) * 64'd7);
	localparam logic [63:0] DECAY_T8 = DECAY_T7 / (64'(TIME_CONST_MS) * 64'd8);

	// exp(-1/260) in Q2.62: even terms add, odd terms subtract.
	localparam logic [63:0] Q62_DECAY = (Q62_ONE + DECAY_T2 + DECAY_T4 + DECAY_T6 + DECAY_T8)
		- (DECAY_T1 + DECAY_T3 + DECAY_T5 + DECAY_T7);

	// One input transaction.
	typedef struct packed {
		logic               frame_start;
		logic [31:0]        time_ms;
		logic [CH_W-1:0]    channel;
		logic signed [31:0] sample_value;
		logic               sample_valid;
	} item_t;

	// One result transaction.
	typedef struct packed {
		logic [CH_W-1:0]    out_channel;
		logic signed [31:0] smoothed_value;
		logic               smoothed_valid;
	} result_t;

	// What the back part does with the channel store for one transaction.
	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_LOAD   = 2'd2,
		OP_SMOOTH = 2'd3
	} op_t;

	// A classified transaction as it waits in the queue.
	typedef struct packed {
		op_t                op;
		logic [CH_W-1:0]    channel;
		logic signed [31:0] sample;
	} entry_t;

	// Product of two Q2.62 values, kept in Q2.62.
	function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

endpackage

>>> src/time_aware_exponential_smoother.sv
// Top level of the time-aware exponential smoother: front, queue and back part.
//
// The block smooths signed Q24.8 samples for up to CHANNELS channels, one sample per
// transaction, and returns one result per transaction in order. A transaction with
// frame_start set latches its time_ms and picks the mode for its frame: samples are
// copied when smoothing_enable is 0, the previous frame time is zero or no valid sample
// has been stored yet; otherwise alpha = 1 - exp(-dt/260), dt clamped to MAX_DELTA_MS,
// comes from a table built at elaboration and each sample moves its channel's value by
// (sample - old) * alpha >>> ALPHA_BITS. A missing sample clears its channel and returns
// an invalid result. The block takes one transaction per clock while the queue is not
// full; each passes the queue, stage one, stage two and the result register.
// Throughput is set by the channel store read-modify-write: a sample for the same
// channel as the one just ahead waits until that one leaves stage one; other orders run
// at full rate. A four-entry queue parts the front from the back. The store comes out of
// reset ready to use; configuration is a single write-enabled bit with no read-back.
module time_aware_exponential_smoother
	import taes_pkg::*;
#(
	parameter int CHANNELS     = 32,
	parameter int MAX_DELTA_MS = 250,
	parameter int ALPHA_BITS   = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_data,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int QW = $bits(entry_t) + ALPHA_BITS + 1;

	logic                q_full;
	logic                q_push;
	entry_t              push_entry;
	logic [ALPHA_BITS:0] push_alpha;
	logic                q_pop;
	logic                q_valid;
	logic [QW-1:0]       q_head;
	entry_t              head_entry;
	logic [ALPHA_BITS:0] head_alpha;

	// Front part: classification and frame timing.
	taes_front #(
		.CHANNELS     (CHANNELS),
		.MAX_DELTA_MS (MAX_DELTA_MS),
		.ALPHA_BITS   (ALPHA_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (push_entry),
		.q_alpha    (push_alpha)
	);

	// Queue between the two parts.
	taes_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  ({push_alpha, push_entry}),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_head)
	);

	assign head_entry = entry_t'(q_head[$bits(entry_t)-1:0]);
	assign head_alpha = q_head[QW-1:$bits(entry_t)];

	// Back part: store update and result register.
	taes_back #(
		.CHANNELS   (CHANNELS),
		.ALPHA_BITS (ALPHA_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_entry      (head_entry),
		.q_alpha      (head_alpha),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> src/taes_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module taes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; a read at the address being written returns the old data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/taes_queue.sv
// Short first-in first-out queue between the front and the back part.
module taes_queue
	import taes_pkg::*;
#(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign full       = (count_q == (PW + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");
`endif

endmodule

>>> src/taes_front.sv
// Front part: accepts transactions, tracks frame timing and classifies each sample.
module taes_front
	import taes_pkg::*;
#(
	parameter int CHANNELS     = 32,
	parameter int MAX_DELTA_MS = 250,
	parameter int ALPHA_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_data,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_t               item,
	input  logic                q_full,
	output logic                q_push,
	output entry_t              q_entry,
	output logic [ALPHA_BITS:0] q_alpha
);

	localparam int DW = $clog2(MAX_DELTA_MS + 1);

	typedef logic [ALPHA_BITS:0] alpha_rom_t [MAX_DELTA_MS + 1];

	// Alpha for every elapsed time from zero up to the clamp, rounded to nearest.
	function automatic alpha_rom_t build_alpha_rom();
		alpha_rom_t  rom;
		logic [63:0] e;
		logic [63:0] r;
		logic [63:0] diff;
		e = Q62_ONE;
		r = Q62_DECAY;
		for (int d = 0; d <= MAX_DELTA_MS; d++) begin
			diff   = Q62_ONE - e;
			rom[d] = (ALPHA_BITS + 1)'((diff + (64'd1 << (61 - ALPHA_BITS))) >> (62 - ALPHA_BITS));
			e      = q62_mul(e, r);
		end
		return rom;
	endfunction

	localparam alpha_rom_t ALPHA_ROM = build_alpha_rom();

	logic                smooth_en_q;
	logic [31:0]         last_time_q;
	logic                holds_q;
	logic                copy_q;
	logic [ALPHA_BITS:0] alpha_q;

	logic                accept;
	logic [31:0]         dt;
	logic [DW-1:0]       dt_idx;
	logic                frame_copy;
	logic                copy_now;
	logic [ALPHA_BITS:0] alpha_now;
	logic                in_range;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign q_push     = accept;

	// Elapsed time since the previous frame start, clamped to the table range.
	always_comb begin
		dt     = item.time_ms - last_time_q;
		dt_idx = (dt > 32'(MAX_DELTA_MS)) ? DW'(MAX_DELTA_MS) : dt[DW-1:0];
	end

	// Frame mode: copy unless smoothing is on and a previous frame with data exists.
	assign frame_copy = !smooth_en_q || (last_time_q == 32'd0) || !holds_q;
	assign copy_now   = item.frame_start ? frame_copy : copy_q;
	assign alpha_now  = item.frame_start ? (frame_copy ? '0 : ALPHA_ROM[dt_idx]) : alpha_q;
	assign in_range   = (32'(item.channel) < 32'(CHANNELS));

	// Classification of the transaction for the back part.
	always_comb begin
		q_entry.channel = item.channel;
		q_entry.sample  = item.sample_value;
		q_alpha         = alpha_now;
		if (!in_range) begin
			q_entry.op = OP_NONE;
		end else if (!item.sample_valid) begin
			q_entry.op = OP_CLEAR;
		end else if (copy_now) begin
			q_entry.op = OP_LOAD;
		end else begin
			q_entry.op = OP_SMOOTH;
		end
	end

	// Configuration and frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_en_q <= 1'b0;
			last_time_q <= '0;
			holds_q     <= 1'b0;
			copy_q      <= 1'b1;
			alpha_q     <= '0;
		end else begin
			if (cfg_we) begin
				smooth_en_q <= cfg_data;
			end
			if (accept) begin
				if (item.frame_start) begin
					last_time_q <= item.time_ms;
					copy_q      <= copy_now;
					alpha_q     <= alpha_now;
				end
				if (in_range && item.sample_valid) begin
					holds_q <= 1'b1;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_smooth_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		!copy_q |-> holds_q)
		else $error("smoothing frame without stored data");
	a_copy_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		copy_q |-> alpha_q == '0)
		else $error("copy frame with a non-zero alpha");
`endif

endmodule

>>> src/taes_back.sv
// Back part: per-channel read-modify-write of the smoothed store and the result register.
module taes_back
	import taes_pkg::*;
#(
	parameter int CHANNELS   = 32,
	parameter int ALPHA_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  entry_t              q_entry,
	input  logic [ALPHA_BITS:0] q_alpha,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW = 33 + ALPHA_BITS + 2;

	// Pipeline control.
	logic                advance;
	logic                hazard;
	logic                s1_vld_q;
	logic                s2_vld_q;
	logic                res_vld_q;

	// Stage one: store read and product.
	entry_t              entry_s1;
	logic [ALPHA_BITS:0] alpha_s1;
	logic [AW-1:0]       idx_s1;
	logic [AW-1:0]       rd_addr;
	logic [31:0]         rd_data;
	logic signed [31:0]  old_val;
	logic                stored_vld;
	op_t                 act_s1;
	logic signed [32:0]  diff;
	logic signed [PW-1:0] prod;

	// Stage two: update and write back.
	op_t                 act_s2;
	logic [CH_W-1:0]     ch_s2;
	logic signed [31:0]  sample_s2;
	logic signed [31:0]  old_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [PW-1:0] step;
	logic signed [31:0]  new_val;
	logic                new_vld;
	logic                wr_req;
	logic                wr_en;
	logic [AW-1:0]       wr_idx;

	// Store state: valid bits in flops, values in RAM, last write kept for forwarding.
	logic [CHANNELS-1:0] vbits_q;
	logic                wb_vld_q;
	logic [AW-1:0]       wb_idx_q;
	logic signed [31:0]  wb_val_q;

	// Result register.
	result_t             res_q;

	// The whole back pipeline moves when the result register can take a transaction.
	assign advance = !res_vld_q || !result_stall;

	// A sample for the channel in stage one waits until that update has left stage one.
	assign hazard = s1_vld_q && (q_entry.channel == entry_s1.channel);
	assign q_pop  = advance && q_valid && !hazard;

	assign idx_s1  = AW'(entry_s1.channel);
	assign rd_addr = advance ? AW'(q_entry.channel) : idx_s1;

	taes_ram #(
		.WIDTH (32),
		.DEPTH (CHANNELS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (new_val),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Stage one: old value with forwarding, resolved action and the scaled difference.
	always_comb begin
		old_val    = (wb_vld_q && (wb_idx_q == idx_s1)) ? wb_val_q : $signed(rd_data);
		stored_vld = (entry_s1.op != OP_NONE) && vbits_q[idx_s1];
		case (entry_s1.op)
			OP_NONE:   act_s1 = OP_NONE;
			OP_CLEAR:  act_s1 = OP_CLEAR;
			OP_LOAD:   act_s1 = OP_LOAD;
			OP_SMOOTH: act_s1 = stored_vld ? OP_SMOOTH : OP_LOAD;
			default:   act_s1 = OP_NONE;
		endcase
		diff = {entry_s1.sample[31], entry_s1.sample} - {old_val[31], old_val};
		prod = PW'(diff) * PW'($signed({1'b0, alpha_s1}));
	end

	// Stage two: the arithmetic shift rounds the step towards minus infinity.
	always_comb begin
		step = prod_s2 >>> ALPHA_BITS;
		case (act_s2)
			OP_NONE: begin
				new_val = '0;
				new_vld = 1'b0;
				wr_req  = 1'b0;
			end
			OP_CLEAR: begin
				new_val = '0;
				new_vld = 1'b0;
				wr_req  = 1'b1;
			end
			OP_LOAD: begin
				new_val = sample_s2;
				new_vld = 1'b1;
				wr_req  = 1'b1;
			end
			OP_SMOOTH: begin
				new_val = old_s2 + step[31:0];
				new_vld = 1'b1;
				wr_req  = 1'b1;
			end
			default: begin
				new_val = '0;
				new_vld = 1'b0;
				wr_req  = 1'b0;
			end
		endcase
	end

	assign wr_en  = advance && s2_vld_q && wr_req;
	assign wr_idx = AW'(ch_s2);

	// Control registers and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			s2_vld_q  <= 1'b0;
			res_vld_q <= 1'b0;
			vbits_q   <= '0;
			wb_vld_q  <= 1'b0;
		end else begin
			if (advance) begin
				s1_vld_q  <= q_pop;
				s2_vld_q  <= s1_vld_q;
				res_vld_q <= s2_vld_q;
			end
			if (wr_en) begin
				vbits_q[wr_idx] <= new_vld;
				wb_vld_q        <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			entry_s1  <= q_entry;
			alpha_s1  <= q_alpha;
			act_s2    <= act_s1;
			ch_s2     <= entry_s1.channel;
			sample_s2 <= entry_s1.sample;
			old_s2    <= old_val;
			prod_s2   <= prod;
			res_q.out_channel    <= ch_s2;
			res_q.smoothed_value <= new_val;
			res_q.smoothed_valid <= new_vld;
		end
		if (wr_en) begin
			wb_idx_q <= wr_idx;
			wb_val_q <= new_val;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_no_same_channel_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q && s2_vld_q |-> entry_s1.channel != ch_s2)
		else $error("two updates of one channel in flight");
	a_valid_bit_written: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vbits_q[$past(wr_idx)] == $past(new_vld))
		else $error("store valid bit does not follow the write");
	a_invalid_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && !res_q.smoothed_valid |-> res_q.smoothed_value == 32'sd0)
		else $error("missing result carries a non-zero value");
`endif

endmodule
